// ===== rtl/core/cmap_pkg.sv =====
// Shared types and constants for the colormap lookup block.
package cmap_pkg;
  localparam int MAX_POINTS_DEF   = 16;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int POS_BITS         = 16;
  localparam int SAMPLE_BITS      = 16;
  localparam int COUNT_BITS       = 5;
  localparam int INDEX_BITS       = 4;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RANGE_MIN   = 2'd0,
    CFG_RANGE_MAX   = 2'd1,
    CFG_POINT_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SEARCH,
    ST_WEIGHT,
    ST_MIX,
    ST_OUT
  } back_state_t;

  // One classified lookup handed from the front part to the back part.
  typedef struct packed {
    logic [SAMPLE_BITS:0] num;    // clamped sample minus range_min
    logic [SAMPLE_BITS:0] den;    // range width
    logic                 empty;  // empty range: position is zero
    logic                 flag;   // sample lay outside the range
  } lookup_t;
endpackage

// ===== rtl/core/cmap_div.sv =====
// Restoring divider computing floor((num << 16) / den), one quotient bit a cycle.
module cmap_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] num,
  input  logic [16:0] den,
  output logic        done,
  output logic [16:0] quot
);
  logic [17:0] rem;
  logic [16:0] dreg;
  logic [32:0] shreg;
  logic [5:0]  cnt;
  logic        busy;
  logic [17:0] trial;

  always_comb begin
    trial = {rem[16:0], shreg[32]} - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd33;
        rem   <= '0;
        dreg  <= den;
        shreg <= {num[16:0], 16'd0};
      end else if (busy) begin
        shreg <= {shreg[31:0], 1'b0};
        if (!trial[17]) begin
          rem  <= trial;
          quot <= {quot[15:0], 1'b1};
        end else begin
          rem  <= {rem[16:0], shreg[32]};
          quot <= {quot[15:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/cmap_front.sv =====
// Front part: takes input words, writes control points, classifies lookups into a queue.
module cmap_front #(
  parameter int MAX_POINTS = cmap_pkg::MAX_POINTS_DEF,
  parameter int CHANNEL_BITS = cmap_pkg::CHANNEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [3:0]             point_index,
  input  logic [15:0]            point_pos,
  input  logic [4*CHANNEL_BITS-1:0] point_chans,
  input  logic [15:0]            sample_value,
  input  logic [15:0]            range_min,
  input  logic [15:0]            range_max,
  output logic                   wr_en,
  output logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  output logic [16+4*CHANNEL_BITS-1:0] wr_data,
  output logic                   q_valid,
  input  logic                   q_ready,
  output cmap_pkg::lookup_t      q_data
);
  localparam int QD = cmap_pkg::QUEUE_DEPTH;
  cmap_pkg::lookup_t queue [QD];
  logic [0:0] wp, rp;
  logic [1:0] fill;
  cmap_pkg::lookup_t cls;
  logic [15:0] v;
  logic push, pop;

  // A control point write waits until no lookup is queued or in progress,
  // so it never overtakes a lookup that is still to read the table.
  assign in_ready = (fill != 2'(QD))
                    && ((cmd == cmap_pkg::CMD_LOOKUP) || ((fill == 2'd0) && q_ready));
  assign push = in_valid && in_ready && (cmd == cmap_pkg::CMD_LOOKUP);
  assign pop  = q_valid && q_ready;
  assign q_valid = (fill != 2'd0);
  assign q_data  = queue[rp];

  always_comb begin
    v = sample_value;
    if (v < range_min) v = range_min;
    if (v > range_max) v = range_max;
    cls.flag  = (sample_value < range_min) || (sample_value > range_max);
    cls.empty = (range_max <= range_min);
    cls.num   = {1'b0, v - range_min};
    cls.den   = {1'b0, range_max - range_min};
  end

  assign wr_en   = in_valid && in_ready && (cmd == cmap_pkg::CMD_WRITE)
                   && ({28'd0, point_index} < 32'(MAX_POINTS));
  assign wr_addr = $clog2(MAX_POINTS)'(point_index);
  assign wr_data = {point_chans, point_pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) queue[wp] <= cls;
  end
endmodule

// ===== rtl/core/cmap_back.sv =====
// Back part: normalizes, searches the segment, weighs and mixes the four channels.
module cmap_back #(
  parameter int MAX_POINTS = cmap_pkg::MAX_POINTS_DEF,
  parameter int CHANNEL_BITS = cmap_pkg::CHANNEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [$clog2(MAX_POINTS)-1:0] wr_addr,
  input  logic [16+4*CHANNEL_BITS-1:0] wr_data,
  input  logic [4:0]             point_count,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  cmap_pkg::lookup_t      q_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4*CHANNEL_BITS-1:0] out_chans,
  output logic                   out_flag
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int EW = 16 + 4*CHANNEL_BITS;
  localparam int CB = CHANNEL_BITS;

  logic [EW-1:0] mem [MAX_POINTS];
  logic [EW-1:0] rd;
  logic [AW-1:0] raddr;

  cmap_pkg::back_state_t state, state_next;
  cmap_pkg::lookup_t job;
  logic [16:0] pos, w;
  logic [AW-1:0] idx, last;
  logic [EW-1:0] e_lo, e_hi;
  logic [1:0] ch;
  logic [1:0] rdph;
  logic div_start, div_done;
  logic [16:0] div_num, div_den, div_q;
  logic wdiv;
  logic [CB+17:0] acc;
  logic [4*CB-1:0] res;
  logic [AW:0] n_eff;
  logic step, seg_flat;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[raddr];
  end

  cmap_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q)
  );

  always_comb begin
    if (point_count < 5'd2) n_eff = (AW+1)'(2);
    else if ({27'd0, point_count} > 32'(MAX_POINTS)) n_eff = (AW+1)'(MAX_POINTS);
    else n_eff = (AW+1)'(point_count);
  end

  logic [15:0] plo, phi;
  assign plo = e_lo[15:0];
  assign phi = e_hi[15:0];

  // The search moves on while the upper point of the segment lies below the position.
  assign step     = (idx != last) && ({1'b0, rd[15:0]} < pos);
  assign seg_flat = (phi <= plo) || (pos <= {1'b0, plo});

  always_comb begin
    logic [CB-1:0] c0, c1;
    c0 = e_lo[16 + ch*CB +: CB];
    c1 = e_hi[16 + ch*CB +: CB];
    acc = (CB+18)'(c0) * (CB+18)'(17'd65536 - w) + (CB+18)'(c1) * (CB+18)'(w)
          + (CB+18)'(32768);
  end

  assign q_ready   = (state == cmap_pkg::ST_IDLE);
  assign out_valid = (state == cmap_pkg::ST_OUT);
  assign out_chans = res;
  assign out_flag  = job.flag;

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    div_num = job.num;
    div_den = job.den;
    case (state)
      cmap_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = cmap_pkg::ST_NORM;
          if (!q_data.empty) begin
            div_start = 1'b1;
            div_num = q_data.num;
            div_den = q_data.den;
          end
        end
      end
      cmap_pkg::ST_NORM: begin
        if (job.empty || div_done) state_next = cmap_pkg::ST_SEARCH;
      end
      cmap_pkg::ST_SEARCH: begin
        if (rdph != 2'd0 && !step) state_next = cmap_pkg::ST_WEIGHT;
      end
      cmap_pkg::ST_WEIGHT: begin
        if (rdph == 2'd3) begin
          if (!wdiv) begin
            if (seg_flat || pos >= {1'b0, phi}) state_next = cmap_pkg::ST_MIX;
            else begin
              div_start = 1'b1;
              div_num = pos - {1'b0, plo};
              div_den = {1'b0, phi - plo};
            end
          end else if (div_done) state_next = cmap_pkg::ST_MIX;
        end
      end
      cmap_pkg::ST_MIX: begin
        if (ch == 2'd3) state_next = cmap_pkg::ST_OUT;
      end
      cmap_pkg::ST_OUT: begin
        if (out_ready) state_next = cmap_pkg::ST_IDLE;
      end
      default: state_next = cmap_pkg::ST_IDLE;
    endcase
  end

  // In the search, rdph tracks the registered read of each table entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmap_pkg::ST_IDLE;
      rdph <= '0;
      wdiv <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        cmap_pkg::ST_IDLE: begin
          if (q_valid) begin
            job <= q_data;
            if (q_data.empty) pos <= '0;
          end
        end
        cmap_pkg::ST_NORM: begin
          if (job.empty || div_done) begin
            if (div_done) pos <= div_q;
            idx <= '0;
            last <= AW'(n_eff - (AW+1)'(2));
            raddr <= AW'(1);
            rdph <= '0;
          end
        end
        cmap_pkg::ST_SEARCH: begin
          // Address idx+1 was issued; its data arrives in the next cycle.
          if (rdph == 2'd0) rdph <= 2'd1;
          else begin
            rdph <= 2'd0;
            if (step) begin
              idx <= idx + 1'b1;
              raddr <= idx + AW'(2);
            end else raddr <= idx;
          end
        end
        cmap_pkg::ST_WEIGHT: begin
          case (rdph)
            2'd0: begin raddr <= idx + 1'b1; rdph <= 2'd1; end
            2'd1: begin e_lo <= rd; rdph <= 2'd2; end
            2'd2: begin e_hi <= rd; rdph <= 2'd3; wdiv <= 1'b0; end
            default: begin
              if (!wdiv) begin
                if (seg_flat) begin
                  w <= '0; ch <= '0;
                end else if (pos >= {1'b0, phi}) begin
                  w <= 17'd65536; ch <= '0;
                end else wdiv <= 1'b1;
              end else if (div_done) begin
                w <= div_q; ch <= '0;
              end
            end
          endcase
        end
        cmap_pkg::ST_MIX: begin
          res[ch*CB +: CB] <= acc[16 +: CB];
          ch <= ch + 2'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/core/colormap_lookup_interp.sv =====
// Top level of the piecewise-linear colormap lookup.
// A lookup word enters a two-entry queue. A serial divide normalizes the
// sample (skipped for an empty range), the segment search reads one table
// entry at a time through the single registered read port (one to fifteen
// entries), the segment ends are fetched and the weight is settled, with a
// further divide when the weight needs one, and the four channels are mixed
// in turn. Lookups are handled one after another; the queue keeps taking
// lookup words while a result waits. A control point write gives no result
// and is taken only when the queue is empty and the back end is idle, so it
// never overtakes a lookup.
module colormap_lookup_interp #(
  parameter int MAX_POINTS = cmap_pkg::MAX_POINTS_DEF,
  parameter int CHANNEL_BITS = cmap_pkg::CHANNEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_index[3:0], point_pos, point_red, point_green, point_blue,
  // point_alpha, sample_value (16 bits each), 4 zero bits
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red, out_green, out_blue, out_alpha (16 bits each), clamped, 7 zero bits
  output logic [71:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  localparam int CB = CHANNEL_BITS;
  logic [15:0] range_min, range_max;
  logic [4:0]  point_count;
  logic wr_en, q_valid, q_ready, oflag;
  logic [$clog2(MAX_POINTS)-1:0] wr_addr;
  logic [16+4*CB-1:0] wr_data;
  logic [4*CB-1:0] chans, och;
  cmap_pkg::lookup_t q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= 16'd0;
      range_max <= 16'hFFFF;
      point_count <= 5'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        cmap_pkg::CFG_RANGE_MIN:   range_min <= cfg_data;
        cmap_pkg::CFG_RANGE_MAX:   range_max <= cfg_data;
        cmap_pkg::CFG_POINT_COUNT: point_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // A stored channel keeps the low CHANNEL_BITS bits of its 16-bit field.
  always_comb begin
    for (int k = 0; k < 4; k++) chans[k*CB +: CB] = CB'(s_axis_tdata[20 + 16*k +: 16]);
  end

  cmap_front #(.MAX_POINTS(MAX_POINTS), .CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .cmd(s_axis_tuser), .point_index(s_axis_tdata[3:0]),
    .point_pos(s_axis_tdata[19:4]), .point_chans(chans),
    .sample_value(s_axis_tdata[99:84]), .range_min, .range_max,
    .wr_en, .wr_addr, .wr_data, .q_valid, .q_ready, .q_data
  );

  cmap_back #(.MAX_POINTS(MAX_POINTS), .CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk, .rst, .wr_en, .wr_addr, .wr_data, .point_count,
    .q_valid, .q_ready, .q_data, .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready), .out_chans(och), .out_flag(oflag)
  );

  assign m_axis_tdata = {7'd0, oflag,
                         16'(och[3*CB +: CB]), 16'(och[2*CB +: CB]),
                         16'(och[CB +: CB]), 16'(och[0 +: CB])};

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_q_take: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !m_axis_tvalid)
    else $error("result shown in the cycle after a lookup was taken");
endmodule
